@@ sv/vram_display_scanout_assert.svh @@
// Assertion macros for the scan-out block: implication, next-cycle and never checks.
// Depends on nothing; included by the top level only.
`ifndef VRAM_DISPLAY_SCANOUT_ASSERT_SVH
`define VRAM_DISPLAY_SCANOUT_ASSERT_SVH

`ifndef ASSERT_OFF

`define VDS_ASSERT_IMPLY(label, ck, rn, a, b) \
    label: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("vds: implication check failed");

`define VDS_ASSERT_NEXT(label, ck, rn, a, b) \
    label: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("vds: next-cycle check failed");

`define VDS_ASSERT_NEVER(label, ck, rn, a) \
    label: assert property (@(posedge ck) disable iff (!rn) !(a)) \
        else $error("vds: forbidden condition seen");

`else

`define VDS_ASSERT_IMPLY(label, ck, rn, a, b)

`define VDS_ASSERT_NEXT(label, ck, rn, a, b)

`define VDS_ASSERT_NEVER(label, ck, rn, a)

`endif

`endif

@@ sv/vds_pkg.sv @@
// Shared types, constants and helpers for the video memory scan-out block.
// Depends on nothing; imported by vram_display_scanout, vds_front and vds_back.
`timescale 1ns / 1ps

package vds_pkg;

    localparam int STORE_COLUMNS_DEF = 1024;
    localparam int STORE_ROWS_DEF    = 512;

    localparam int WORD_ADDR_W = 19;
    localparam int WORD_W      = 16;
    localparam int COLOR_W     = 8;

    localparam int LEFT_W   = 10;
    localparam int TOP_W    = 9;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 10;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 3;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LEFT   = 3'd0,
        CFG_WINDOW_TOP    = 3'd1,
        CFG_WINDOW_WIDTH  = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_PACKED_24BIT  = 3'd4
    } vds_cfg_index_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [WORD_ADDR_W-1:0] word_address;
        logic [WORD_W-1:0]      word_data;
    } vds_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               line_end;
        logic               frame_end;
    } vds_pix_t;

    // Classified beat as it travels from front to back (addresses travel beside it)
    typedef struct packed {
        logic              is_write;
        logic              lo_odd;     // first word sits in the odd bank
        logic              odd_byte;   // packed pixel starts on an odd byte
        logic              mode24;
        logic              line_end;
        logic              frame_end;
        logic [WORD_W-1:0] word_data;
    } vds_cmd_flags_t;

    typedef struct packed {
        logic clearing;
        logic oq_push;
        logic oq_push_ready;
    } vds_back_stat_t;

    // 5-bit channel to 8 bits by replicating the top bits
    function automatic logic [COLOR_W-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

@@ sv/vram_display_scanout.sv @@
// Top level of the video memory scan-out block: front end, command queue, back end.
// Depends on vds_pkg, vds_front, vds_fifo, vds_back and vram_display_scanout_assert.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   cfg     | in        | cfg_write              | cfg_index, cfg_data
//   req     | in        | req_valid / req_ready  | req  (vds_req_t)
//   pix     | out       | pix_valid / pix_ready  | pix  (vds_pix_t)
//
// Rate: one beat per clock in each direction while pix_ready holds high; a pixel passes
//   the command queue, the bank read register and the output queue on its way out.
// Two banks of STORE_COLUMNS*STORE_ROWS/2 words (even and odd word index) give the two
//   reads a packed 24-bit pixel needs in the same cycle.
// Reset: both banks are swept to zero, one entry per cycle, over all
//   STORE_COLUMNS*STORE_ROWS/2 entries of each bank; req_ready stays low
//   meanwhile, configuration writes are taken throughout.
// Stalls: the command queue lets the front take beats while the back waits on pix_ready;
//   reads are issued only with room reserved in the output queue.
`timescale 1ns / 1ps
`include "vram_display_scanout_assert.svh"

module vram_display_scanout
    import vds_pkg::*;
#(
    parameter int STORE_COLUMNS = STORE_COLUMNS_DEF,
    parameter int STORE_ROWS    = STORE_ROWS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  vds_req_t               req,
    output logic                   pix_valid,
    input  logic                   pix_ready,
    output vds_pix_t               pix
);

    // Word index width, minus the bank select bit
    localparam int BW    = $clog2(STORE_COLUMNS * STORE_ROWS) - 1;
    localparam int CMD_W = 2 * BW + $bits(vds_cmd_flags_t);
    localparam int CQW   = $clog2(CMD_DEPTH + 1);

    vds_back_stat_t stat;

    // Front side of the command queue
    logic           f_valid, f_ready;
    vds_cmd_flags_t f_flags;
    logic [BW-1:0]  f_addr_even, f_addr_odd;

    // Back side of the command queue
    logic           b_valid, b_ready;
    vds_cmd_flags_t b_flags;
    logic [BW-1:0]  b_addr_even, b_addr_odd;
    logic [CMD_W-1:0] q_push_data, q_pop_data;
    logic [CQW-1:0]   cmd_count;

    // Front: hold window registers and the raster position, classify each beat as a
    // store write or a pixel read, and work out both bank addresses.
    vds_front #(
        .STORE_COLUMNS (STORE_COLUMNS),
        .STORE_ROWS    (STORE_ROWS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .clearing      (stat.clearing),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd_flags     (f_flags),
        .cmd_addr_even (f_addr_even),
        .cmd_addr_odd  (f_addr_odd)
    );

    assign q_push_data = {f_addr_even, f_addr_odd, f_flags};
    assign {b_addr_even, b_addr_odd, b_flags} = q_pop_data;

    // Decouple the front from stalls at the output; keeps beats in arrival order, so a
    // write always lands before any later read of the same word.
    vds_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_push_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_pop_data),
        .count      (cmd_count)
    );

    // Back: run writes and reads against the banks, format pixels, buffer them.
    vds_back #(
        .STORE_COLUMNS (STORE_COLUMNS),
        .STORE_ROWS    (STORE_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (b_valid),
        .cmd_ready     (b_ready),
        .cmd_flags     (b_flags),
        .cmd_addr_even (b_addr_even),
        .cmd_addr_odd  (b_addr_odd),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .pix           (pix),
        .stat          (stat)
    );

    // No request beat may enter while the banks are being swept
    `VDS_ASSERT_NEVER(a_no_req_while_clearing, clk, rst_n, stat.clearing && req_ready)
    // Read credit must guarantee room for every formatted pixel
    `VDS_ASSERT_IMPLY(a_out_queue_room, clk, rst_n, stat.oq_push, stat.oq_push_ready)
    // Nothing is read during the sweep, so no pixel can be offered
    `VDS_ASSERT_IMPLY(a_no_pixel_while_clearing, clk, rst_n, stat.clearing, !pix_valid)
    // The sweep runs once per reset and never restarts
    `VDS_ASSERT_NEXT(a_clear_once, clk, rst_n, !stat.clearing, !stat.clearing)
    // The command queue never holds more beats than it has slots
    `VDS_ASSERT_NEVER(a_cmd_queue_bound, clk, rst_n, cmd_count > CQW'(CMD_DEPTH))

endmodule

@@ sv/vds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for both word banks of the video store.
`timescale 1ns / 1ps

module vds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/vds_fifo.sv @@
// Small first-in first-out queue of registers with valid/ready on both sides.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps

module vds_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNTW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/vds_front.sv @@
// Front end: window registers, scan counters, beat classification and address math.
// Depends on vds_pkg; feeds the command queue in front of vds_back.
`timescale 1ns / 1ps

module vds_front
    import vds_pkg::*;
#(
    parameter int STORE_COLUMNS = STORE_COLUMNS_DEF,
    parameter int STORE_ROWS    = STORE_ROWS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [CFG_INDEX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  vds_req_t                             req,
    input  logic                                 clearing,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output vds_cmd_flags_t                       cmd_flags,
    output logic [$clog2(STORE_COLUMNS*STORE_ROWS)-2:0] cmd_addr_even,
    output logic [$clog2(STORE_COLUMNS*STORE_ROWS)-2:0] cmd_addr_odd
);

    localparam int CW  = $clog2(STORE_COLUMNS);
    localparam int RW  = $clog2(STORE_ROWS);
    localparam int AW  = CW + RW;
    localparam int CW1 = CW + 1;
    localparam int CW2 = CW + 2;
    localparam int RW1 = RW + 1;
    localparam logic [CW1-1:0] COLS_V = CW1'(STORE_COLUMNS);
    localparam logic [RW1-1:0] ROWS_V = RW1'(STORE_ROWS);

    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                packed_reg, packed_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;

    logic           accept, is_write, full_win, mode24, line_end, frame_end;
    logic [CW1-1:0] w_eff;
    logic [RW1-1:0] h_eff;
    logic [CW-1:0]  left_eff, col_wr;
    logic [RW-1:0]  top_eff, row_wr;
    logic [CW2-1:0] col3;
    logic [AW-1:0]  base, pix_idx, idx0, idx1;

    assign req_ready = cmd_ready && !clearing;
    assign cmd_valid = req_valid && !clearing;
    assign accept    = req_valid && req_ready;
    assign is_write  = req.req_type == REQ_WRITE;

    // Effective window: zero size means full store at the origin, 15-bit; oversize clamps to the store
    always_comb
    begin
        full_win = (width_reg == '0) || (height_reg == '0);
        if (full_win || 32'(width_reg) > STORE_COLUMNS)
        begin
            w_eff = COLS_V;
        end
        else
        begin
            w_eff = CW1'(width_reg);
        end
        if (full_win || 32'(height_reg) > STORE_ROWS)
        begin
            h_eff = ROWS_V;
        end
        else
        begin
            h_eff = RW1'(height_reg);
        end
        left_eff = full_win ? '0 : CW'(left_reg);
        top_eff  = full_win ? '0 : RW'(top_reg);
        mode24   = !full_win && packed_reg;
    end

    always_comb
    begin
        row_wr  = top_eff + row_reg;
        col_wr  = left_eff + col_reg;
        col3    = CW2'({col_reg, 1'b0}) + CW2'(col_reg);
        base    = {row_wr, left_eff};
        pix_idx = mode24 ? base + AW'(col3[CW2-1:1]) : {row_wr, col_wr};
        idx0    = is_write ? AW'(req.word_address) : pix_idx;
        idx1    = idx0 + 1'b1;
        // Adjacent words always land in opposite banks
        cmd_addr_even = idx0[0] ? idx1[AW-1:1] : idx0[AW-1:1];
        cmd_addr_odd  = idx0[0] ? idx0[AW-1:1] : idx1[AW-1:1];
        line_end  = (CW1'(col_reg) + 1'b1) >= w_eff;
        frame_end = line_end && ((RW1'(row_reg) + 1'b1) >= h_eff);
    end

    always_comb
    begin
        cmd_flags.is_write  = is_write;
        cmd_flags.lo_odd    = idx0[0];
        cmd_flags.odd_byte  = col_reg[0];
        cmd_flags.mode24    = mode24;
        cmd_flags.line_end  = line_end;
        cmd_flags.frame_end = frame_end;
        cmd_flags.word_data = req.word_data;
    end

    // Advance the raster position on each accepted pixel beat
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && !is_write)
        begin
            if (line_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        width_next  = width_reg;
        height_next = height_reg;
        packed_next = packed_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEFT:   left_next   = cfg_data[LEFT_W-1:0];
                CFG_WINDOW_TOP:    top_next    = cfg_data[TOP_W-1:0];
                CFG_WINDOW_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                CFG_WINDOW_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                CFG_PACKED_24BIT:  packed_next = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            packed_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            packed_reg <= packed_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

@@ sv/vds_back.sv @@
// Back end: even/odd word banks, clearing pass, read issue, pixel format, output queue.
// Depends on vds_pkg, vds_ram and vds_fifo.
`timescale 1ns / 1ps

module vds_back
    import vds_pkg::*;
#(
    parameter int STORE_COLUMNS = STORE_COLUMNS_DEF,
    parameter int STORE_ROWS    = STORE_ROWS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  vds_cmd_flags_t                       cmd_flags,
    input  logic [$clog2(STORE_COLUMNS*STORE_ROWS)-2:0] cmd_addr_even,
    input  logic [$clog2(STORE_COLUMNS*STORE_ROWS)-2:0] cmd_addr_odd,
    output logic                                 pix_valid,
    input  logic                                 pix_ready,
    output vds_pix_t                             pix,
    output vds_back_stat_t                       stat
);

    localparam int BANK_DEPTH = STORE_COLUMNS * STORE_ROWS / 2;
    localparam int BW         = $clog2(BANK_DEPTH);
    localparam int OQW        = $clog2(OUT_DEPTH + 1);
    localparam int OCW        = OQW + 1;

    logic              clearing_reg, clearing_next;
    logic [BW-1:0]     clr_addr_reg, clr_addr_next;
    logic              b1_valid_reg;
    vds_cmd_flags_t    b1_flags_reg;

    logic              issue, credit_ok, pix_pop, oq_push_ready;
    logic [OQW-1:0]    oq_count;
    logic [OCW-1:0]    occ;
    logic              we_even, we_odd;
    logic [WORD_W-1:0] wdata_even, wdata_odd, rdata_even, rdata_odd;
    logic [BW-1:0]     waddr_even, waddr_odd;
    logic [WORD_W-1:0] first, second;
    logic [23:0]       sel24;
    vds_pix_t          pix_d;

    // Reserve room in the output queue for every read in flight
    assign pix_pop   = pix_valid && pix_ready;
    assign occ       = OCW'(oq_count) + OCW'(b1_valid_reg);
    assign credit_ok = (occ - OCW'(pix_pop)) < OCW'(OUT_DEPTH);
    assign cmd_ready = !clearing_reg && (cmd_flags.is_write || credit_ok);
    assign issue     = cmd_valid && cmd_ready;

    always_comb
    begin
        we_even    = clearing_reg || (issue && cmd_flags.is_write && !cmd_flags.lo_odd);
        we_odd     = clearing_reg || (issue && cmd_flags.is_write && cmd_flags.lo_odd);
        wdata_even = clearing_reg ? '0 : cmd_flags.word_data;
        wdata_odd  = clearing_reg ? '0 : cmd_flags.word_data;
        waddr_even = clearing_reg ? clr_addr_reg : cmd_addr_even;
        waddr_odd  = clearing_reg ? clr_addr_reg : cmd_addr_odd;
    end

    vds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr_even),
        .wdata (wdata_even),
        .raddr (cmd_addr_even),
        .rdata (rdata_even)
    );

    vds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr_odd),
        .wdata (wdata_odd),
        .raddr (cmd_addr_odd),
        .rdata (rdata_odd)
    );

    // Sweep both banks once after reset
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == BW'(BANK_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            b1_valid_reg <= issue && !cmd_flags.is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_flags_reg <= cmd_flags;
    end

    // Format the pixel from the registered bank words: both when packed, the first when 15-bit
    always_comb
    begin
        first  = b1_flags_reg.lo_odd ? rdata_odd : rdata_even;
        second = b1_flags_reg.lo_odd ? rdata_even : rdata_odd;
        sel24  = b1_flags_reg.odd_byte ? {second, first[15:8]} : {second[7:0], first};
        if (b1_flags_reg.mode24)
        begin
            pix_d.red   = sel24[7:0];
            pix_d.green = sel24[15:8];
            pix_d.blue  = sel24[23:16];
        end
        else
        begin
            pix_d.red   = widen5(first[4:0]);
            pix_d.green = widen5(first[9:5]);
            pix_d.blue  = widen5(first[14:10]);
        end
        pix_d.line_end  = b1_flags_reg.line_end;
        pix_d.frame_end = b1_flags_reg.frame_end;
    end

    vds_fifo #(
        .WIDTH ($bits(vds_pix_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (b1_valid_reg),
        .push_ready (oq_push_ready),
        .push_data  (pix_d),
        .pop_valid  (pix_valid),
        .pop_ready  (pix_ready),
        .pop_data   (pix),
        .count      (oq_count)
    );

    assign stat.clearing      = clearing_reg;
    assign stat.oq_push       = b1_valid_reg;
    assign stat.oq_push_ready = oq_push_ready;

endmodule

@@ tb/vram_display_scanout_tb.sv @@
// Self-checking testbench for the video memory scan-out block vram_display_scanout.
// Depends on vds_pkg for the request/pixel beat types and register indexes.
// The testbench predicts every pixel from its own copy of the store, window and scan counters.
`timescale 1ns / 1ps

module vram_display_scanout_tb;
    import vds_pkg::*;

    localparam int unsigned COLS  = STORE_COLUMNS_DEF;
    localparam int unsigned ROWS  = STORE_ROWS_DEF;
    localparam int unsigned WORDS = COLS * ROWS;

    // Writes make no pixel, so once every owed pixel has come, wait DRAIN_CYCLES
    // for them to land before touching a register.
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned IDLE_PCT     = 6;
    localparam int unsigned HOLD_OFF_LEN = 300;
    localparam int unsigned MAX_PRINTS   = 40;

    // First register index past the list; writes there must be dropped
    localparam int unsigned CFG_INDEX_SPARE = CFG_PACKED_24BIT + 1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   req_valid;
    logic                   req_ready;
    vds_req_t               req;
    logic                   pix_valid;
    logic                   pix_ready;
    vds_pix_t               pix;

    vram_display_scanout dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // ------------------------------------------------------------------
    // Shadow state of the block: store contents, registers, scan counters
    // ------------------------------------------------------------------
    bit [WORD_W-1:0]   vram_mirror [WORDS];
    bit [LEFT_W-1:0]   cur_left;
    bit [TOP_W-1:0]    cur_top;
    bit [WIDTH_W-1:0]  cur_width;
    bit [HEIGHT_W-1:0] cur_height;
    bit                cur_packed;
    int unsigned       scan_col_m;
    int unsigned       scan_row_m;

    // Pixels owed by the block, oldest first
    vds_pix_t    pixels_due [$];
    int unsigned mismatch_count;

    // Idle rates of the two sides; zero gives a stretch of back-to-back beats
    int unsigned sender_idle_pct = IDLE_PCT;
    int unsigned sink_idle_pct   = IDLE_PCT;

    // Bumped by a test to ask the pixel sink for one long hold-off
    int unsigned hold_off_requests;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop: reset sweep of the store plus all traffic is far below this
    initial
    begin
        #15_000_000;
        $display("** vram_display_scanout: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Replicate the top bits of a 5-bit channel into the low bits of 8
    function automatic logic [COLOR_W-1:0] expand5(input logic [4:0] v);
        return (COLOR_W'(v) << 3) | (COLOR_W'(v) >> 2);
    endfunction

    // Window actually scanned: zero size forces the full store, 15-bit, at the origin;
    // oversize is clamped to the store
    function automatic void resolve_window(output int unsigned w, h, lft, tp,
                                           output bit mode24);
        w      = 32'(cur_width);
        h      = 32'(cur_height);
        lft    = cur_left % COLS;
        tp     = cur_top % ROWS;
        mode24 = cur_packed;
        if (w == 0 || h == 0)
        begin
            w      = COLS;
            h      = ROWS;
            lft    = 0;
            tp     = 0;
            mode24 = 1'b0;
        end
        if (w > COLS)
            w = COLS;
        if (h > ROWS)
            h = ROWS;
    endfunction

    // Byte address of a packed pixel, or word index of a 15-bit pixel
    function automatic int unsigned source_addr(input int unsigned row, input int unsigned col);
        int unsigned w, h, lft, tp, row_w;
        bit          mode24;
        resolve_window(w, h, lft, tp, mode24);
        row_w = (tp + row) % ROWS;
        if (mode24)
            return (row_w * COLS + lft) * 2 + col * 3;
        return row_w * COLS + (lft + col) % COLS;
    endfunction

    // Pixel the block owes for the next request; advance the raster counters
    function automatic vds_pix_t next_scan_pixel();
        int unsigned     w, h, lft, tp, loc, first;
        bit              mode24;
        bit [31:0]       bytes;
        bit [WORD_W-1:0] word;
        vds_pix_t        p;
        resolve_window(w, h, lft, tp, mode24);
        loc = source_addr(scan_row_m, scan_col_m);
        if (mode24)
        begin
            // Two adjacent words form a little-endian byte stream; odd start drops a byte
            first = (loc >> 1) % WORDS;
            bytes = {vram_mirror[(first + 1) % WORDS], vram_mirror[first]};
            if (loc[0])
                bytes = bytes >> 8;
            p.red   = bytes[7:0];
            p.green = bytes[15:8];
            p.blue  = bytes[23:16];
        end
        else
        begin
            word    = vram_mirror[loc];
            p.red   = expand5(word[4:0]);
            p.green = expand5(word[9:5]);
            p.blue  = expand5(word[14:10]);
        end
        // A counter at or past a shrunk window's edge ends its line or frame at once
        p.line_end  = (scan_col_m + 1 >= w);
        p.frame_end = p.line_end && (scan_row_m + 1 >= h);
        if (p.line_end)
        begin
            scan_col_m = 0;
            scan_row_m = p.frame_end ? 0 : scan_row_m + 1;
        end
        else
            scan_col_m = scan_col_m + 1;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: pixel mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_pixel(input vds_pix_t got);
        vds_pix_t want;
        if (pixels_due.size() == 0)
        begin
            report_mismatch("unrequested pixel", 32'(got), 0);
            return;
        end
        want = pixels_due.pop_front();
        if (got.red !== want.red)
            report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
            report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
            report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.line_end !== want.line_end)
            report_mismatch("line_end", 32'(got.line_end), 32'(want.line_end));
        if (got.frame_end !== want.frame_end)
            report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
    endtask

    // Pixel sink: check each beat taken at the edge, then pick ready for the next cycle.
    // Values read right at the edge are the pre-edge ones, since the block and this
    // bench both update through nonblocking assignments.
    initial
    begin : pixel_sink
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pix_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_valid === 1'b1 && pix_ready === 1'b1)
                check_pixel(pix);
            if (hold_seen != hold_off_requests)
            begin
                hold_seen = hold_off_requests;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left != 0)
            begin
                // Long hold-off, counted here: the block fills and stalls its input
                hold_left--;
                pix_ready <= 1'b0;
            end
            else
                pix_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one request beat and hold it until taken; the shadow state moves at that edge.
    // Valid is left high on return so the next beat can follow without a gap.
    task automatic send_beat(input logic kind, input int unsigned addr, input int unsigned data);
        vds_req_t beat;
        beat.req_type     = kind;
        beat.word_address = addr[WORD_ADDR_W-1:0];
        beat.word_data    = data[WORD_W-1:0];
        if ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        if (beat.req_type == REQ_PIXEL)
            pixels_due.push_back(next_scan_pixel());
        else
            vram_mirror[beat.word_address % WORDS] = beat.word_data;
    endtask

    // Drop valid and wait for every owed pixel, then let trailing writes land
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the block takes it at the next edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_WINDOW_LEFT:   cur_left   = value[LEFT_W-1:0];
            CFG_WINDOW_TOP:    cur_top    = value[TOP_W-1:0];
            CFG_WINDOW_WIDTH:  cur_width  = value[WIDTH_W-1:0];
            CFG_WINDOW_HEIGHT: cur_height = value[HEIGHT_W-1:0];
            CFG_PACKED_24BIT:  cur_packed = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_window(input int unsigned lft, input int unsigned tp,
                              input int unsigned w, input int unsigned h,
                              input int unsigned packed24);
        write_reg(CFG_WINDOW_LEFT, lft);
        write_reg(CFG_WINDOW_TOP, tp);
        write_reg(CFG_WINDOW_WIDTH, w);
        write_reg(CFG_WINDOW_HEIGHT, h);
        write_reg(CFG_PACKED_24BIT, packed24);
    endtask

    task automatic send_pixels(input int unsigned count);
        for (int k = 0; k < count; k++)
            send_beat(REQ_PIXEL, $urandom, $urandom);
    endtask

    // Window origin biased toward the store edges, where the wraps happen
    function automatic int unsigned pick_origin(input int unsigned span);
        case ($urandom_range(3))
            0:       return 0;
            1:       return span - 1;
            default: return $urandom_range(span - 1);
        endcase
    endfunction

    // Mixed traffic for the current window: mostly pixel requests, writes aimed at
    // words the window reads so the pixels carry data, some writes anywhere
    task automatic run_traffic_phase(input int unsigned n_items);
        int unsigned w, h, lft, tp, loc, addr, data;
        bit          mode24;
        resolve_window(w, h, lft, tp, mode24);
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(9) < 7)
                send_beat(REQ_PIXEL, $urandom, $urandom);
            else
            begin
                if ($urandom_range(4) == 0)
                    addr = $urandom_range(WORDS - 1);
                else
                begin
                    loc  = source_addr($urandom_range(h - 1), $urandom_range(w - 1));
                    addr = mode24 ? ((loc >> 1) + $urandom_range(1)) % WORDS : loc;
                end
                case ($urandom_range(5))
                    0:       data = 0;
                    1:       data = 'hFFFF;
                    default: data = $urandom;
                endcase
                send_beat(REQ_WRITE, addr, data);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Store is cleared by reset; default registers scan the full store from the origin
    task automatic test_reset_contents();
        send_pixels(3);
    endtask

    // 5:5:5 widening at the channel extremes, top bit ignored, last store word written
    task automatic test_color_expansion();
        send_beat(REQ_WRITE, 3, 'h7FFF);
        send_beat(REQ_WRITE, 4, 'h8000);
        send_beat(REQ_WRITE, 5, 'h4021);
        send_beat(REQ_WRITE, 6, 'hFFFF);
        send_beat(REQ_WRITE, WORDS - 1, 'hFFFF);
        send_pixels(4);
        wait_drained();
    endtask

    // Packed pixels straddling the last and first store words, even then odd byte start;
    // the counters sit past the new two-pixel line, so the first pixel ends at once
    task automatic test_packed_wrap();
        set_window(COLS - 1, ROWS - 1, 2, 1, 1);
        send_beat(REQ_WRITE, WORDS - 1, 'h1234);
        send_beat(REQ_WRITE, 0, 'h5678);
        send_beat(REQ_WRITE, 1, 'h9ABC);
        send_pixels(3);
        wait_drained();
    endtask

    // Zero width or zero height overrides origin and packed mode
    task automatic test_zero_size();
        set_window(100, 200, 0, 5, 1);
        send_pixels(2);
        wait_drained();
        set_window(100, 200, 5, 0, 1);
        send_pixels(1);
        wait_drained();
    endtask

    // Shrink width past the column counter, then height past the row counter
    task automatic test_window_shrink();
        set_window(10, 20, 8, 4, 0);
        send_pixels(8);
        wait_drained();
        write_reg(CFG_WINDOW_WIDTH, 3);
        send_pixels(1);
        wait_drained();
        write_reg(CFG_WINDOW_HEIGHT, 1);
        send_pixels(3);
        wait_drained();
    endtask

    // Writes beyond the register list must leave the window alone
    task automatic test_spare_index();
        for (int i = CFG_INDEX_SPARE; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), '1);
        send_pixels(2);
        wait_drained();
    endtask

    // Random windows and traffic; a few phases run with neither side idling
    task automatic test_random_traffic();
        int unsigned wd, ht;
        for (int ph = 0; ph < 10; ph++)
        begin
            wd = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
            ht = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            sender_idle_pct = (ph >= 3 && ph <= 5) ? 0 : IDLE_PCT;
            sink_idle_pct   = sender_idle_pct;
            set_window(pick_origin(COLS), pick_origin(ROWS), wd, ht, $urandom_range(1));
            run_traffic_phase(30);
            wait_drained();
        end
        sender_idle_pct = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
    endtask

    // Oversize widths and heights clamp to the store, so the first pixels of a line
    // or a frame must not end it early
    task automatic test_clamped_sizes();
        set_window(pick_origin(COLS), pick_origin(ROWS), 2047, 1, $urandom_range(1));
        send_pixels(6);
        wait_drained();
        set_window(pick_origin(COLS), pick_origin(ROWS), COLS + 1, 1, 0);
        send_pixels(6);
        wait_drained();
        set_window(pick_origin(COLS), pick_origin(ROWS), 1, 1023, 0);
        send_pixels(6);
        wait_drained();
        set_window(pick_origin(COLS), pick_origin(ROWS), 1, ROWS + 1, 0);
        send_pixels(6);
        wait_drained();
    endtask

    // Sink holds off long enough to back the block up into its input; midway the
    // sender also stops until every owed pixel has come
    task automatic test_output_stall();
        set_window(pick_origin(COLS), pick_origin(ROWS), 5, 3, $urandom_range(1));
        hold_off_requests++;
        run_traffic_phase(30);
        wait_drained();
        run_traffic_phase(20);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The store sweep after reset keeps req_ready low; the first beat just waits
        test_reset_contents();
        test_color_expansion();
        test_packed_wrap();
        test_zero_size();
        test_window_shrink();
        test_spare_index();
        test_random_traffic();
        test_clamped_sizes();
        test_output_stall();

        wait_drained();
        if (mismatch_count == 0)
            $display("** vram_display_scanout: PASSED **");
        else
            $display("** vram_display_scanout: FAILED **");
        $finish;
    end

endmodule
